### rtl/clist_pkg.sv
package clist_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int NAME_BYTES   = 20;
    localparam int NAME_W       = 160;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_NEXT   = 2'd2,
        REQ_FIRST  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_END  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] name2;
        logic [63:0] name1;
        logic [63:0] name0;
        logic [7:0]  age;
        logic [7:0]  sex;
        logic [13:0] grade;
    } t_rec;

    // zero every byte past NAME_BYTES and past the first zero byte
    function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] res;
        logic              ended;
        logic [7:0]        v;
        res   = '0;
        ended = 1'b0;
        for (int i = 0; i < NAME_W / 8; i++) begin
            v = raw[8*i +: 8];
            if ((i >= NAME_BYTES) || ended) begin
                v = 8'd0;
            end
            if (v == 8'd0) begin
                ended = 1'b1;
            end
            res[8*i +: 8] = v;
        end
        return res;
    endfunction

endpackage

### rtl/cursor_linked_list_core.sv
// Singly linked list of records with one cursor, over a fixed node store.
// Request channel: drive the request fields and raise start; the item is taken
// at a rising edge where start is high and busy is low. busy rises in the next
// cycle and stays high while the item is worked on.
// Result channel: o_strobe is high for exactly one cycle and carries o_status,
// o_has_entry and the current record after the step (zero when no entry).
// The receiver cannot stall; each result must be taken in its strobe cycle.
// The result strobe follows the accepting edge through S_EXEC and S_WB; busy
// is already low in the strobe cycle, so the next item can be taken at the edge
// that takes the result.
// This sequence is set by the link memory: one read in the accept cycle, then up
// to two link writes through its single write port; the record memory is read
// for the new current entry alongside the first write.
// Reset (synchronous, active low) empties the list, puts the cursor at the
// head and drops any result in flight. Node memories are not cleared; nodes
// are handed out from the free list first, then from a fresh counter.
module cursor_linked_list_core #(
    parameter int CAPACITY = clist_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [63:0] i_name_part0,
    input  logic [63:0] i_name_part1,
    input  logic [31:0] i_name_part2,
    input  logic [7:0]  i_age_in,
    input  logic [7:0]  i_sex_in,
    input  logic [13:0] i_grade_in,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic        o_has_entry,
    output logic [63:0] o_cur_name0,
    output logic [63:0] o_cur_name1,
    output logic [31:0] o_cur_name2,
    output logic [7:0]  o_cur_age,
    output logic [7:0]  o_cur_sex,
    output logic [13:0] o_cur_grade
);
    import clist_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] NULL_P = PW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WB   = 3'b100
    } t_state;

    t_state          r_state, n_state;
    t_req            r_req;
    t_rec            r_rec;
    logic [PW-1:0]   r_head, n_head;
    logic [PW-1:0]   r_owner, n_owner;
    logic [PW-1:0]   r_free, n_free;
    logic [PW-1:0]   r_fresh, n_fresh;
    logic [PW-1:0]   r_cur, n_cur;
    logic [PW-1:0]   r_count, n_count;
    t_status         r_status, n_status;
    logic            r_use_in, n_use_in;
    logic            r_wb_we, n_wb_we;
    logic [AW-1:0]   r_wb_addr;
    logic [PW-1:0]   r_wb_data, n_wb_data;

    logic            accept;
    logic            cur_node, owner_node;
    logic [PW-1:0]   alloc;
    logic            alloc_ok;
    logic            slot_we;
    logic [PW-1:0]   slot_val;
    logic            l_we;
    logic [AW-1:0]   l_waddr;
    logic [PW-1:0]   l_wdata;
    logic            lm_we;
    logic [AW-1:0]   lm_waddr;
    logic [PW-1:0]   lm_wdata;
    logic [AW-1:0]   lm_raddr;
    logic [PW-1:0]   lm_rdata;
    logic            rm_we;
    t_rec            rm_rdata;
    t_rec            out_rec;
    logic            out_has;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    clist_link_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (PW)
    ) u_link_mem (
        .i_clk   (i_clk),
        .i_we    (lm_we),
        .i_waddr (lm_waddr),
        .i_wdata (lm_wdata),
        .i_raddr (lm_raddr),
        .o_rdata (lm_rdata)
    );

    clist_rec_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_rec_mem (
        .i_clk   (i_clk),
        .i_we    (rm_we),
        .i_waddr (alloc[AW-1:0]),
        .i_wdata (r_rec),
        .i_raddr (n_cur[AW-1:0]),
        .o_rdata (rm_rdata)
    );

    assign lm_raddr = (i_req_type == REQ_INSERT) ? r_free[AW-1:0] : r_cur[AW-1:0];
    assign lm_we    = (r_state == S_EXEC) ? l_we : ((r_state == S_WB) && r_wb_we);
    assign lm_waddr = (r_state == S_EXEC) ? l_waddr : r_wb_addr;
    assign lm_wdata = (r_state == S_EXEC) ? l_wdata : r_wb_data;
    assign rm_we    = (r_state == S_EXEC) && (r_req == REQ_INSERT) && alloc_ok;

    assign cur_node   = (r_cur < NULL_P);
    assign owner_node = (r_owner < NULL_P);

    always_comb begin
        n_cur     = r_cur;
        n_free    = r_free;
        n_fresh   = r_fresh;
        n_owner   = r_owner;
        n_head    = r_head;
        n_count   = r_count;
        n_status  = ST_DONE;
        n_use_in  = 1'b0;
        n_wb_we   = 1'b0;
        n_wb_data = r_wb_data;
        slot_we   = 1'b0;
        slot_val  = r_cur;
        l_we      = 1'b0;
        l_waddr   = r_cur[AW-1:0];
        l_wdata   = r_free;
        alloc     = NULL_P;
        alloc_ok  = 1'b0;
        if (r_free < NULL_P) begin
            alloc    = r_free;
            alloc_ok = 1'b1;
        end else if (r_fresh < NULL_P) begin
            alloc    = r_fresh;
            alloc_ok = 1'b1;
        end
        case (r_req)
            REQ_INSERT: begin
                if (alloc_ok) begin
                    if (r_free < NULL_P) begin
                        n_free = lm_rdata;
                    end else begin
                        n_fresh = r_fresh + PW'(1);
                    end
                    l_we     = 1'b1;
                    l_waddr  = alloc[AW-1:0];
                    l_wdata  = r_cur;
                    slot_we  = 1'b1;
                    slot_val = alloc;
                    n_cur    = alloc;
                    n_count  = r_count + PW'(1);
                    n_use_in = 1'b1;
                end else begin
                    n_status = ST_FULL;
                end
            end
            REQ_DELETE: begin
                if (cur_node) begin
                    l_we     = 1'b1;
                    l_waddr  = r_cur[AW-1:0];
                    l_wdata  = r_free;
                    n_free   = r_cur;
                    slot_we  = 1'b1;
                    slot_val = lm_rdata;
                    n_cur    = lm_rdata;
                    if (r_count != '0) begin
                        n_count = r_count - PW'(1);
                    end
                end else begin
                    n_status = ST_END;
                end
            end
            REQ_NEXT: begin
                if (cur_node) begin
                    n_owner = r_cur;
                    n_cur   = lm_rdata;
                end else begin
                    n_status = ST_END;
                end
            end
            REQ_FIRST: begin
                n_owner = NULL_P;
                n_cur   = r_head;
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
        if (slot_we) begin
            if (owner_node) begin
                n_wb_we   = 1'b1;
                n_wb_data = slot_val;
            end else begin
                n_head = slot_val;
            end
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_WB;
            S_WB:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign out_has = (r_cur < NULL_P);
    always_comb begin
        out_rec = r_use_in ? r_rec : rm_rdata;
        if (!out_has) begin
            out_rec = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= NULL_P;
            r_owner  <= NULL_P;
            r_free   <= NULL_P;
            r_fresh  <= '0;
            r_cur    <= NULL_P;
            r_count  <= '0;
            r_wb_we  <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= (r_state == S_WB);
            if (r_state == S_EXEC) begin
                r_head  <= n_head;
                r_owner <= n_owner;
                r_free  <= n_free;
                r_fresh <= n_fresh;
                r_cur   <= n_cur;
                r_count <= n_count;
                r_wb_we <= n_wb_we;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req       <= t_req'(i_req_type);
            {r_rec.name2, r_rec.name1, r_rec.name0} <=
                clean_name({i_name_part2, i_name_part1, i_name_part0});
            r_rec.age   <= i_age_in;
            r_rec.sex   <= i_sex_in;
            r_rec.grade <= i_grade_in;
        end
        if (r_state == S_EXEC) begin
            r_status  <= n_status;
            r_use_in  <= n_use_in;
            r_wb_addr <= r_owner[AW-1:0];
            r_wb_data <= n_wb_data;
        end
        if (r_state == S_WB) begin
            o_status    <= r_status;
            o_has_entry <= out_has;
            o_cur_name0 <= out_rec.name0;
            o_cur_name1 <= out_rec.name1;
            o_cur_name2 <= out_rec.name2;
            o_cur_age   <= out_rec.age;
            o_cur_sex   <= out_rec.sex;
            o_cur_grade <= out_rec.grade;
        end
    end

    a_strobe_after_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_WB))
        else $error("result strobe without a write-back cycle");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted item did not start execution");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NULL_P)
        else $error("entry count exceeds capacity");

    a_full_really: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_FULL)) |-> ((r_fresh == NULL_P) && (r_free == NULL_P)))
        else $error("full status with nodes still available");

    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh <= NULL_P)
        else $error("fresh node counter past capacity");

endmodule

### rtl/clist_link_mem.sv
module clist_link_mem #(
    parameter int DEPTH = clist_pkg::CAPACITY_DEF,
    parameter int AW    = 6,
    parameter int DW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/clist_rec_mem.sv
module clist_rec_mem #(
    parameter int DEPTH = clist_pkg::CAPACITY_DEF,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  clist_pkg::t_rec  i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output clist_pkg::t_rec  o_rdata
);
    import clist_pkg::*;

    t_rec r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
